/* sv/mme_pkg.sv */
// shared constants, types and helpers of the matrix multiply engine
package mme_pkg;

    // sizing
    localparam int MAX_DIM     = 8;
    localparam int DATA_WIDTH  = 16;
    localparam int ELEM_W      = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
    localparam int DEPTH       = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int ACC_W       = PROD_W + DIM_W + 1;
    localparam int FRAC_BITS   = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // fixed field widths
    localparam int CFG_W   = 4;
    localparam int CIDX_W  = 2;
    localparam int INDEX_W = 6;
    localparam int VALUE_W = 16;
    localparam int POS_W   = 3;

    // saturation bounds at element width
    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((64'sd1 <<< (ELEM_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    // configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        REG_ROWS_M  = 2'd0,
        REG_INNER_K = 2'd1,
        REG_COLS_N  = 2'd2
    } t_reg;

    // item classes
    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_LOAD_A = 2'd1,
        OP_LOAD_B = 2'd2,
        OP_GO     = 2'd3
    } t_op;

    // queued item
    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [ELEM_W-1:0] value;
    } t_item;

    // dimension registers handed to the back end
    typedef struct packed {
        logic [CFG_W-1:0] rows_m;
        logic [CFG_W-1:0] inner_k;
        logic [CFG_W-1:0] cols_n;
    } t_dims;

    // tag that travels with each product through the datapath
    typedef struct packed {
        logic             first;
        logic             endsum;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic             last;
    } t_tag;

    // clamp a dimension register to 1..MAX_DIM and return its last index
    function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = '0;
        end else if (32'(v) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM - 1);
        end else begin
            r = DIM_W'(v - CFG_W'(1));
        end
        return r;
    endfunction

    // floor to q8.8, saturate to element width, sign-extend to the port
    function automatic logic [VALUE_W-1:0] finish_sum(input logic signed [ACC_W-1:0] sum);
        logic signed [ACC_W-1:0]  q;
        logic signed [ELEM_W-1:0] s;
        q = sum >>> FRAC_BITS;
        if (q > SAT_HI) begin
            s = SAT_HI[ELEM_W-1:0];
        end else if (q < SAT_LO) begin
            s = SAT_LO[ELEM_W-1:0];
        end else begin
            s = q[ELEM_W-1:0];
        end
        return VALUE_W'(s);
    endfunction

endpackage

/* sv/mme_front.sv */
// front end: takes input beats, classifies them and queues them for the back end
module mme_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_which_matrix,
    input  logic [mme_pkg::INDEX_W-1:0]    i_element_index,
    input  logic signed [mme_pkg::VALUE_W-1:0] i_element_value,
    input  logic                           i_go,
    output logic                           o_q_valid,
    output mme_pkg::t_item                 o_q_item,
    input  logic                           i_q_pop
);

    mme_pkg::t_item              r_queue [mme_pkg::QUEUE_DEPTH];
    logic [mme_pkg::QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [mme_pkg::QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [mme_pkg::QPTR_W:0]    r_count, n_count;
    mme_pkg::t_op                op;
    mme_pkg::t_item              item;
    logic                        push;

    // classify the beat
    always_comb begin
        if (i_go) begin
            op = mme_pkg::OP_GO;
        end else if (32'(i_element_index) >= mme_pkg::DEPTH) begin
            op = mme_pkg::OP_NOP;
        end else if (i_which_matrix) begin
            op = mme_pkg::OP_LOAD_B;
        end else begin
            op = mme_pkg::OP_LOAD_A;
        end
        item.op    = op;
        item.addr  = i_element_index[mme_pkg::ADDR_W-1:0];
        item.value = i_element_value[mme_pkg::ELEM_W-1:0];
    end

    assign busy      = (r_count == (mme_pkg::QPTR_W+1)'(mme_pkg::QUEUE_DEPTH));
    assign push      = start && !busy && (op != mme_pkg::OP_NOP);
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_queue[r_rd_ptr];

    // queue pointers
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == mme_pkg::QPTR_W'(mme_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + mme_pkg::QPTR_W'(1);
        end
        if (i_q_pop) begin
            n_rd_ptr = (r_rd_ptr == mme_pkg::QPTR_W'(mme_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + mme_pkg::QPTR_W'(1);
        end
        if (push && !i_q_pop) begin
            n_count = r_count + (mme_pkg::QPTR_W+1)'(1);
        end else if (!push && i_q_pop) begin
            n_count = r_count - (mme_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= item;
        end
    end

    // fill level stays within the queue
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (mme_pkg::QPTR_W+1)'(mme_pkg::QUEUE_DEPTH))
        else $error("queue overfilled");

    // back end pops only a filled queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule

/* sv/mme_back.sv */
// back end: element stores, product sequencer and multiply-accumulate datapath
module mme_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mme_pkg::t_dims                i_dims,
    input  logic                          i_q_valid,
    input  mme_pkg::t_item                i_q_item,
    output logic                          o_q_pop,
    output logic                          o_valid,
    output logic [mme_pkg::POS_W-1:0]     o_out_row,
    output logic [mme_pkg::POS_W-1:0]     o_out_col,
    output logic signed [mme_pkg::VALUE_W-1:0] o_out_value,
    output logic                          o_last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state                            r_state, n_state;
    logic [mme_pkg::DIM_W-1:0]         r_i, n_i, r_j, n_j, r_t, n_t;
    logic [mme_pkg::DIM_W-1:0]         r_mlast, n_mlast, r_klast, n_klast, r_nlast, n_nlast;
    logic [mme_pkg::ADDR_W-1:0]        r_a_base, n_a_base, r_b_ptr, n_b_ptr;
    logic [mme_pkg::ADDR_W-1:0]        addr_a, k_step, n_step;
    logic                              wr_a, wr_b, issue;
    mme_pkg::t_tag                     tag0;

    logic [mme_pkg::ELEM_W-1:0]        mem_a [mme_pkg::DEPTH];
    logic [mme_pkg::ELEM_W-1:0]        mem_b [mme_pkg::DEPTH];
    logic [mme_pkg::ELEM_W-1:0]        r_rd_a, r_rd_b;
    logic                              r_v1, r_v2;
    mme_pkg::t_tag                     r_tag1, r_tag2;
    logic signed [mme_pkg::PROD_W-1:0] r_prod;
    logic signed [mme_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic                              r_out_valid;
    logic [mme_pkg::POS_W-1:0]         r_out_row, r_out_col;
    logic [mme_pkg::VALUE_W-1:0]       r_out_value;
    logic                              r_out_last;

    assign k_step = mme_pkg::ADDR_W'(r_klast) + mme_pkg::ADDR_W'(1);
    assign n_step = mme_pkg::ADDR_W'(r_nlast) + mme_pkg::ADDR_W'(1);
    assign addr_a = r_a_base + mme_pkg::ADDR_W'(r_t);

    // tag of the product issued this cycle
    always_comb begin
        tag0.first  = (r_t == '0);
        tag0.endsum = (r_t == r_klast);
        tag0.row    = r_i;
        tag0.col    = r_j;
        tag0.last   = (r_i == r_mlast) && (r_j == r_nlast);
    end

    // sequencer: pop items, run i/j/t walk for a go
    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_t      = r_t;
        n_mlast  = r_mlast;
        n_klast  = r_klast;
        n_nlast  = r_nlast;
        n_a_base = r_a_base;
        n_b_ptr  = r_b_ptr;
        o_q_pop  = 1'b0;
        wr_a     = 1'b0;
        wr_b     = 1'b0;
        issue    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    case (i_q_item.op)
                        mme_pkg::OP_LOAD_A: wr_a = 1'b1;
                        mme_pkg::OP_LOAD_B: wr_b = 1'b1;
                        mme_pkg::OP_GO: begin
                            n_state  = ST_RUN;
                            n_i      = '0;
                            n_j      = '0;
                            n_t      = '0;
                            n_mlast  = mme_pkg::dim_last(i_dims.rows_m);
                            n_klast  = mme_pkg::dim_last(i_dims.inner_k);
                            n_nlast  = mme_pkg::dim_last(i_dims.cols_n);
                            n_a_base = '0;
                            n_b_ptr  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                issue = 1'b1;
                if (r_t != r_klast) begin
                    n_t     = r_t + mme_pkg::DIM_W'(1);
                    n_b_ptr = r_b_ptr + n_step;
                end else begin
                    n_t = '0;
                    if (r_j != r_nlast) begin
                        n_j     = r_j + mme_pkg::DIM_W'(1);
                        n_b_ptr = mme_pkg::ADDR_W'(r_j) + mme_pkg::ADDR_W'(1);
                    end else begin
                        n_j     = '0;
                        n_b_ptr = '0;
                        if (r_i != r_mlast) begin
                            n_i      = r_i + mme_pkg::DIM_W'(1);
                            n_a_base = r_a_base + k_step;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i      <= n_i;
        r_j      <= n_j;
        r_t      <= n_t;
        r_mlast  <= n_mlast;
        r_klast  <= n_klast;
        r_nlast  <= n_nlast;
        r_a_base <= n_a_base;
        r_b_ptr  <= n_b_ptr;
    end

    // element stores with registered read
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            mem_a[i_q_item.addr] <= i_q_item.value;
        end
        if (issue) begin
            r_rd_a <= mem_a[addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            mem_b[i_q_item.addr] <= i_q_item.value;
        end
        if (issue) begin
            r_rd_b <= mem_b[r_b_ptr];
        end
    end

    // accumulate, and finish on the last term of a dot product
    always_comb begin
        if (r_tag2.first) begin
            n_acc = mme_pkg::ACC_W'(r_prod);
        end else begin
            n_acc = r_acc + mme_pkg::ACC_W'(r_prod);
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1        <= issue;
            r_v2        <= r_v1;
            r_out_valid <= r_v2 && r_tag2.endsum;
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        r_tag1 <= tag0;
        r_tag2 <= r_tag1;
        r_prod <= $signed(r_rd_a) * $signed(r_rd_b);
        if (r_v2) begin
            r_acc <= n_acc;
        end
        if (r_v2 && r_tag2.endsum) begin
            r_out_row   <= mme_pkg::POS_W'(r_tag2.row);
            r_out_col   <= mme_pkg::POS_W'(r_tag2.col);
            r_out_value <= mme_pkg::finish_sum(n_acc);
            r_out_last  <= r_tag2.last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_last      = r_out_last;

    // every cycle of a run feeds the read stage
    a_run_feeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |=> r_v1)
        else $error("run cycle did not issue a read");

    // a result beat comes only from a finished dot product
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_v2 && r_tag2.endsum))
        else $error("result beat without finished sum");

    // stores are never written while a run reads them
    a_no_write_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_a || wr_b) |-> (r_state == ST_IDLE))
        else $error("store written during a run");

endmodule

/* sv/matrix_multiply_engine_unit.sv */
// top level of the matrix multiply engine: configuration registers and front/back wiring
//
// usage
//   configuration: write rows_m, inner_k, cols_n (index 0, 1, 2) through
//   i_cfg_we / i_cfg_idx / i_cfg_data while the engine is idle; each resets to 1.
//   input: a beat is taken when start is high and busy is low. a load beat
//   (i_go low) writes one q8.8 element of A or B at its row-major index; a go
//   beat (i_go high) starts C = A * B with the current shape.
//   output: o_valid strobes for one cycle per element of C, in row-major order,
//   with o_out_row, o_out_col, o_out_value and o_last on the final element.
//   timing: beats enter a two-entry queue; busy is high only while it is full.
//   a load leaves the queue once the back end is idle. a go occupies the single
//   multiply-accumulate unit for rows_m * cols_n * inner_k products, one product
//   per cycle, gated by the one read port of each element store; each result
//   passes the store read registers, the product register and the output register
//   after the last term of its dot product is issued.
//   reset: synchronous, active low; clears the queue and the pipeline, sets all
//   dimensions to 1. store contents are undefined until written. the receiver
//   cannot stall, results are never held back.
module matrix_multiply_engine_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mme_pkg::CIDX_W-1:0]         i_cfg_idx,
    input  logic [mme_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_which_matrix,
    input  logic [mme_pkg::INDEX_W-1:0]        i_element_index,
    input  logic signed [mme_pkg::VALUE_W-1:0] i_element_value,
    input  logic                               i_go,
    output logic                               o_valid,
    output logic [mme_pkg::POS_W-1:0]          o_out_row,
    output logic [mme_pkg::POS_W-1:0]          o_out_col,
    output logic signed [mme_pkg::VALUE_W-1:0] o_out_value,
    output logic                               o_last
);

    mme_pkg::t_dims r_dims;
    logic           q_valid;
    logic           q_pop;
    mme_pkg::t_item q_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims.rows_m  <= mme_pkg::CFG_W'(1);
            r_dims.inner_k <= mme_pkg::CFG_W'(1);
            r_dims.cols_n  <= mme_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mme_pkg::REG_ROWS_M:  r_dims.rows_m  <= i_cfg_data;
                mme_pkg::REG_INNER_K: r_dims.inner_k <= i_cfg_data;
                mme_pkg::REG_COLS_N:  r_dims.cols_n  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // accept and queue
    mme_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_which_matrix  (i_which_matrix),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_go            (i_go),
        .o_q_valid       (q_valid),
        .o_q_item        (q_item),
        .i_q_pop         (q_pop)
    );

    // stores and multiply-accumulate
    mme_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dims      (r_dims),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

endmodule
